@@ sv/vchs_pkg.sv @@
package vchs_pkg;

  // default physical table depth, log2
  localparam int MAX_SLOTS_LOG2_DEF = 12;

  localparam logic [3:0] TABLE_LOG2_RESET = 4'd12;
  localparam logic [4:0] TABLE_LOG2_MIN   = 5'd4;

  localparam int KEY_W  = 16;
  localparam int HASH_W = 32;
  // slot word: occupied bit over {z, y, x}
  localparam int SLOT_W = 3 * KEY_W + 1;

  localparam logic [HASH_W-1:0] PRIME_X = 32'd73856093;
  localparam logic [HASH_W-1:0] PRIME_Y = 32'd19349663;
  localparam logic [HASH_W-1:0] PRIME_Z = 32'd83492791;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_HASH_X,
    ST_HASH_Y,
    ST_HASH_Z,
    ST_SEED,
    ST_READ,
    ST_COMPARE,
    ST_CLEAR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic  capture;
    logic  hash_en;
    axis_t hash_axis;
    logic  probe_start;
    logic  rd_en;
    logic  step;
    logic  wr_key;
    logic  sweep_en;
    logic  set_found;
    logic  set_full;
    logic  load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       solid;
    logic       slot_empty;
    logic       slot_match;
    logic       probe_last;
    logic       sweep_last;
    logic       out_free;
  } dp_status_t;

endpackage

@@ sv/voxel_coordinate_hash_set.sv @@
// clear sweeps every slot of the physical table empty before its result is loaded
// insert / query: hash x, y and z, seed the probe, then probe; one probe is a slot read then a compare
// non-solid insert and unused func go straight to the result
// one item at a time; the next item can be taken in the cycle after its result is loaded
// reset (rst, synchronous) sets the size register to 12 and then sweeps the slot
// memory empty, stalling input until the sweep ends
module voxel_coordinate_hash_set #(
  parameter int MAX_SLOTS_LOG2 = vchs_pkg::MAX_SLOTS_LOG2_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // size register
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_wr_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic signed [15:0] key_x,
  input  logic signed [15:0] key_y,
  input  logic signed [15:0] key_z,
  input  logic               solid,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               found,
  output logic               table_full
);

  // controller issues one command word per cycle, datapath reports back
  vchs_pkg::ctrl_cmd_t  cmd;
  vchs_pkg::dp_status_t status;

  // sequencing: hash x, y, z through one multiplier, seed the probe, then read and
  // compare one slot at a time until empty, match or wrap; clear and reset sweep the slots
  vchs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // key and hash registers, probe pointer, slot memory with the occupied
  // bit stored beside each key, and the output register
  vchs_dp #(
    .MAX_SLOTS_LOG2 (MAX_SLOTS_LOG2)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .func        (func),
    .key_x       (key_x),
    .key_y       (key_y),
    .key_z       (key_z),
    .solid       (solid),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .table_full  (table_full),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

@@ sv/vchs_ram.sv @@
module vchs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/vchs_ctrl.sv @@
module vchs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  vchs_pkg::dp_status_t status,
  output vchs_pkg::ctrl_cmd_t  cmd
);

  vchs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vchs_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.hash_axis = vchs_pkg::AXIS_X;
    in_stall   = (state != vchs_pkg::ST_IDLE);
    unique case (state)
      vchs_pkg::ST_INIT: begin
        cmd.sweep_en = 1'b1;
        if (status.sweep_last) begin
          state_next = vchs_pkg::ST_IDLE;
        end
      end
      vchs_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (status.func)
            vchs_pkg::FUNC_CLEAR:  state_next = vchs_pkg::ST_CLEAR;
            vchs_pkg::FUNC_INSERT: state_next = status.solid ? vchs_pkg::ST_HASH_X
                                                             : vchs_pkg::ST_RESP;
            vchs_pkg::FUNC_QUERY:  state_next = vchs_pkg::ST_HASH_X;
            default:               state_next = vchs_pkg::ST_RESP;
          endcase
        end
      end
      vchs_pkg::ST_HASH_X: begin
        cmd.hash_en   = 1'b1;
        cmd.hash_axis = vchs_pkg::AXIS_X;
        state_next    = vchs_pkg::ST_HASH_Y;
      end
      vchs_pkg::ST_HASH_Y: begin
        cmd.hash_en   = 1'b1;
        cmd.hash_axis = vchs_pkg::AXIS_Y;
        state_next    = vchs_pkg::ST_HASH_Z;
      end
      vchs_pkg::ST_HASH_Z: begin
        cmd.hash_en   = 1'b1;
        cmd.hash_axis = vchs_pkg::AXIS_Z;
        state_next    = vchs_pkg::ST_SEED;
      end
      vchs_pkg::ST_SEED: begin
        cmd.probe_start = 1'b1;
        state_next      = vchs_pkg::ST_READ;
      end
      vchs_pkg::ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = vchs_pkg::ST_COMPARE;
      end
      vchs_pkg::ST_COMPARE: begin
        priority if (status.slot_empty) begin
          cmd.wr_key = (status.func == vchs_pkg::FUNC_INSERT);
          state_next = vchs_pkg::ST_RESP;
        end else if (status.slot_match) begin
          cmd.set_found = 1'b1;
          state_next    = vchs_pkg::ST_RESP;
        end else if (status.probe_last) begin
          cmd.set_full = (status.func == vchs_pkg::FUNC_INSERT);
          state_next   = vchs_pkg::ST_RESP;
        end else begin
          cmd.step   = 1'b1;
          state_next = vchs_pkg::ST_READ;
        end
      end
      vchs_pkg::ST_CLEAR: begin
        cmd.sweep_en = 1'b1;
        if (status.sweep_last) begin
          state_next = vchs_pkg::ST_RESP;
        end
      end
      vchs_pkg::ST_RESP: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = vchs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = vchs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/vchs_dp.sv @@
module vchs_dp #(
  parameter int MAX_SLOTS_LOG2 = vchs_pkg::MAX_SLOTS_LOG2_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [3:0]                  cfg_wr_data,
  input  logic [1:0]                  func,
  input  logic signed [15:0]          key_x,
  input  logic signed [15:0]          key_y,
  input  logic signed [15:0]          key_z,
  input  logic                        solid,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic                        table_full,
  input  vchs_pkg::ctrl_cmd_t         cmd,
  output vchs_pkg::dp_status_t        status
);

  localparam int AW    = MAX_SLOTS_LOG2;
  localparam int DEPTH = 1 << MAX_SLOTS_LOG2;
  localparam logic [AW-1:0] ALL_ONES = '1;
  localparam logic [4:0]    AW_L2    = 5'(AW);

  logic [3:0]                      table_log2;
  logic [1:0]                      op;
  logic                            op_solid;
  logic [3*vchs_pkg::KEY_W-1:0]    key;
  logic [vchs_pkg::HASH_W-1:0]     hash_acc;
  logic [AW-1:0]                   mask;
  logic [AW-1:0]                   idx;
  logic [AW-1:0]                   visited;
  logic [AW-1:0]                   sweep_addr;
  logic                            res_found;
  logic                            res_full;

  logic [4:0]                      act_log2;
  logic [AW-1:0]                   mask_calc;
  logic [vchs_pkg::KEY_W-1:0]      coord;
  logic [vchs_pkg::HASH_W-1:0]     mult_a;
  logic [vchs_pkg::HASH_W-1:0]     mult_b;
  logic [vchs_pkg::HASH_W-1:0]     product;
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [vchs_pkg::SLOT_W-1:0]     ram_wdata;
  logic [vchs_pkg::SLOT_W-1:0]     ram_rdata;

  // active size clamped to [4, AW]
  always_comb begin
    priority if ({1'b0, table_log2} < vchs_pkg::TABLE_LOG2_MIN) begin
      act_log2 = vchs_pkg::TABLE_LOG2_MIN;
    end else if ({1'b0, table_log2} > AW_L2) begin
      act_log2 = AW_L2;
    end else begin
      act_log2 = {1'b0, table_log2};
    end
    mask_calc = ALL_ONES >> (AW_L2 - act_log2);
  end

  // one shared multiplier, one axis per cycle
  always_comb begin
    unique case (cmd.hash_axis)
      vchs_pkg::AXIS_X: begin
        coord  = key[15:0];
        mult_b = vchs_pkg::PRIME_X;
      end
      vchs_pkg::AXIS_Y: begin
        coord  = key[31:16];
        mult_b = vchs_pkg::PRIME_Y;
      end
      vchs_pkg::AXIS_Z: begin
        coord  = key[47:32];
        mult_b = vchs_pkg::PRIME_Z;
      end
      default: begin
        coord  = key[15:0];
        mult_b = vchs_pkg::PRIME_X;
      end
    endcase
    mult_a  = {{16{coord[15]}}, coord};
    product = mult_a * mult_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_log2 <= vchs_pkg::TABLE_LOG2_RESET;
      sweep_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        table_log2 <= cfg_wr_data;
      end
      if (cmd.sweep_en) begin
        sweep_addr <= sweep_addr + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op        <= func;
      op_solid  <= solid;
      key       <= {key_z, key_y, key_x};
      hash_acc  <= '0;
      res_found <= 1'b0;
      res_full  <= 1'b0;
    end
    if (cmd.hash_en) begin
      hash_acc <= hash_acc ^ product;
    end
    if (cmd.probe_start) begin
      mask    <= mask_calc;
      idx     <= hash_acc[AW-1:0] & mask_calc;
      visited <= '0;
    end
    if (cmd.step) begin
      idx     <= (idx + 1'b1) & mask;
      visited <= visited + 1'b1;
    end
    if (cmd.set_found) begin
      res_found <= 1'b1;
    end
    if (cmd.set_full) begin
      res_full <= 1'b1;
    end
    if (cmd.load_out) begin
      found      <= res_found;
      table_full <= res_full;
    end
  end

  assign ram_we    = cmd.sweep_en | cmd.wr_key;
  assign ram_waddr = cmd.sweep_en ? sweep_addr : idx;
  assign ram_wdata = cmd.sweep_en ? '0 : {1'b1, key};

  vchs_ram #(
    .WIDTH (vchs_pkg::SLOT_W),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    status.func       = cmd.capture ? func : op;
    status.solid      = cmd.capture ? solid : op_solid;
    status.slot_empty = !ram_rdata[vchs_pkg::SLOT_W-1];
    status.slot_match = (ram_rdata[vchs_pkg::SLOT_W-2:0] == key);
    status.probe_last = (visited == mask);
    status.sweep_last = (sweep_addr == ALL_ONES);
    status.out_free   = !out_valid || !out_stall;
  end

endmodule

@@ tb/voxel_coordinate_hash_set_tb.sv @@
module voxel_coordinate_hash_set_tb;

  // physical table depth of the instance, log2
  localparam int MAX_LOG2 = vchs_pkg::MAX_SLOTS_LOG2_DEF;
  localparam int SLOT_COUNT = 1 << MAX_LOG2;
  // func 3 is not decoded by the block
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // long receiver hold-off, long enough to back the block up to its input
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_ITEMS = 112;

  // expected outcome of one transfer in
  typedef struct packed {
    logic found;
    logic full;
  } outcome_t;

  // shadow copy of the hash set, predicts every result in order
  class voxel_set_tracker;
    bit          slot_used [SLOT_COUNT];
    logic [47:0] slot_coord [SLOT_COUNT];
    logic [3:0]  size_log2;
    outcome_t    expected_outcomes [$];
    int          failures;

    function new();
      size_log2 = vchs_pkg::TABLE_LOG2_RESET;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      failures = 0;
    endfunction

    function void set_size(logic [3:0] v);
      size_log2 = v;
    endfunction

    function int unsigned active_log2();
      int unsigned n;
      n = size_log2;
      if (n < vchs_pkg::TABLE_LOG2_MIN) n = vchs_pkg::TABLE_LOG2_MIN;
      if (n > MAX_LOG2) n = MAX_LOG2;
      return n;
    endfunction

    function logic [31:0] home_hash(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      logic [31:0] sx, sy, sz;
      sx = {{16{x[15]}}, x};
      sy = {{16{y[15]}}, y};
      sz = {{16{z[15]}}, z};
      return (sx * vchs_pkg::PRIME_X) ^
             (sy * vchs_pkg::PRIME_Y) ^
             (sz * vchs_pkg::PRIME_Z);
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction

    // walk the probe sequence for one accepted request and queue its outcome
    function void note_request(logic [1:0] f, logic [15:0] x, logic [15:0] y,
                               logic [15:0] z, logic s);
      outcome_t    o;
      logic [47:0] coord;
      int unsigned slots, mask, idx, visits;
      bit          stopped;
      o = '0;
      coord = {z, y, x};
      if (f == vchs_pkg::FUNC_CLEAR) begin
        foreach (slot_used[i]) slot_used[i] = 1'b0;
      end else if ((f == vchs_pkg::FUNC_INSERT && s) || f == vchs_pkg::FUNC_QUERY) begin
        slots = 1 << active_log2();
        mask = slots - 1;
        idx = home_hash(x, y, z) & mask;
        visits = 0;
        stopped = 1'b0;
        while (visits < slots && !stopped) begin
          if (!slot_used[idx]) begin
            if (f == vchs_pkg::FUNC_INSERT) begin
              slot_used[idx] = 1'b1;
              slot_coord[idx] = coord;
            end
            stopped = 1'b1;
          end else if (slot_coord[idx] == coord) begin
            o.found = 1'b1;
            stopped = 1'b1;
          end else begin
            idx = (idx + 1) & mask;
          end
          visits++;
        end
        if (!stopped && f == vchs_pkg::FUNC_INSERT) o.full = 1'b1;
      end
      expected_outcomes.push_back(o);
    endfunction

    function void check_response(logic got_found, logic got_full);
      outcome_t e;
      if (expected_outcomes.size() == 0) begin
        if (failures < 10)
          $display("unexpected result: found %0b table_full %0b", got_found, got_full);
        failures++;
        return;
      end
      e = expected_outcomes.pop_front();
      if (got_found !== e.found || got_full !== e.full) begin
        if (failures < 10)
          $display("mismatch: found exp %0b got %0b, table_full exp %0b got %0b",
                   e.found, got_found, e.full, got_full);
        failures++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [3:0]         cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         func;
  logic signed [15:0] key_x;
  logic signed [15:0] key_y;
  logic signed [15:0] key_z;
  logic               solid;
  logic               out_valid;
  logic               out_stall;
  logic               found;
  logic               table_full;

  voxel_set_tracker tracker;

  // idle rates in percent, changed per phase
  int sender_idle_pct;
  int recv_idle_pct;
  // set by the stimulus, cleared by the receiver once its hold-off is over
  bit hold_req;

  // coordinates reused within a phase so that duplicates and hits occur
  logic [47:0] coord_pool [48];
  int          pool_len;
  logic [3:0]  phase_size [PHASE_COUNT];

  voxel_coordinate_hash_set i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .key_x      (key_x),
    .key_y      (key_y),
    .key_z      (key_z),
    .solid      (solid),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .table_full (table_full)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #240_000_000;
    $display("FAIL voxel_coordinate_hash_set");
    $finish;
  end

  // receiver: random stall at the falling edge, plus one long counted hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // every result transfer is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall)
      tracker.check_response(found, table_full);
  end

  // offer one item, called and returning at a falling edge
  task automatic send_item(input logic [1:0] f, input logic [15:0] x,
                           input logic [15:0] y, input logic [15:0] z,
                           input logic s);
    // random gap before the item, valid held low meanwhile
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    key_x    <= x;
    key_y    <= y;
    key_z    <= z;
    solid    <= s;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    // transfer in at this edge
    tracker.note_request(f, x, y, z, s);
    @(negedge clk);
  endtask

  // drop valid and wait until every predicted result has been taken
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // size register write, only while the block is idle
  task automatic write_size(input logic [3:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    tracker.set_size(v);
  endtask

  // fresh coordinate pool; tables of up to 32 slots get 24 keys, larger ones 40
  task automatic fill_pool();
    logic [31:0] a, b;
    pool_len = (tracker.active_log2() <= 5) ? 24 : 40;
    for (int i = 0; i < pool_len; i++) begin
      a = $urandom;
      b = $urandom;
      coord_pool[i] = {a[15:0], b};
    end
  endtask

  task automatic random_item();
    logic [1:0]  f;
    logic [47:0] coord;
    logic [31:0] a, b;
    logic        s;
    int          r;
    r = $urandom_range(99);
    // clear is rare since it sweeps the whole physical table
    if (r < 2) f = vchs_pkg::FUNC_CLEAR;
    else if (r < 5) f = FUNC_UNUSED;
    else if (r < 52) f = vchs_pkg::FUNC_INSERT;
    else f = vchs_pkg::FUNC_QUERY;
    s = ($urandom_range(99) < 88);
    if ($urandom_range(99) < 78) begin
      coord = coord_pool[$urandom_range(pool_len - 1)];
    end else begin
      a = $urandom;
      b = $urandom;
      coord = {a[15:0], b};
    end
    send_item(f, coord[15:0], coord[31:16], coord[47:32], s);
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 4'd0;
    in_valid = 1'b0;
    func = vchs_pkg::FUNC_CLEAR;
    key_x = 16'sd0;
    key_y = 16'sd0;
    key_z = 16'sd0;
    solid = 1'b0;
    hold_req = 1'b0;
    sender_idle_pct = 26;
    recv_idle_pct = 58;
    phase_size = '{4'd4, 4'd15, 4'd0, 4'd9, 4'd12, 4'd5, 4'd13, 4'd4};

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset size; the post-reset sweep stalls the first transfer
    send_item(vchs_pkg::FUNC_INSERT, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_item(vchs_pkg::FUNC_INSERT, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
    send_item(vchs_pkg::FUNC_INSERT, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_item(vchs_pkg::FUNC_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(vchs_pkg::FUNC_INSERT, 16'h7FFF, 16'h8000, 16'h0000, 1'b1);
    // duplicate insert reports found and changes nothing
    send_item(vchs_pkg::FUNC_INSERT, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_item(vchs_pkg::FUNC_QUERY,  16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_item(vchs_pkg::FUNC_QUERY,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(vchs_pkg::FUNC_QUERY,  16'h0001, 16'h0002, 16'h0003, 1'b0);
    // insert of air is a no-op
    send_item(vchs_pkg::FUNC_INSERT, 16'h0001, 16'h0002, 16'h0003, 1'b0);
    send_item(vchs_pkg::FUNC_QUERY,  16'h0001, 16'h0002, 16'h0003, 1'b1);
    // undecoded func
    send_item(FUNC_UNUSED,           16'h0005, 16'h0005, 16'h0005, 1'b1);
    send_item(vchs_pkg::FUNC_QUERY,  16'h0000, 16'h0000, 16'h0000, 1'b0);
    // clear empties everything
    send_item(vchs_pkg::FUNC_CLEAR,  16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
    send_item(vchs_pkg::FUNC_QUERY,  16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_item(vchs_pkg::FUNC_QUERY,  16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_item(vchs_pkg::FUNC_INSERT, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_item(vchs_pkg::FUNC_QUERY,  16'h0000, 16'h0000, 16'h0000, 1'b1);

    // random phases; no clear between them, so resizes keep old entries
    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_all_results();
      write_size(phase_size[p]);
      // idle mix: sender light / receiver heavy, then swapped, then none
      if (p < 3) begin
        sender_idle_pct = 26;
        recv_idle_pct = 58;
      end else if (p < 6) begin
        sender_idle_pct = 58;
        recv_idle_pct = 26;
      end else begin
        sender_idle_pct = 0;
        recv_idle_pct = 0;
      end
      fill_pool();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender pause until the block has fully drained
        if (p == 1 && n == PHASE_ITEMS / 2) wait_all_results();
        // receiver holds off while items keep coming
        if (p == 6 && n == 40) hold_req = 1'b1;
        random_item();
      end
    end

    wait_all_results();
    // trailing window for any stray result
    repeat (40) @(negedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("PASS voxel_coordinate_hash_set");
    end else begin
      $display("FAIL voxel_coordinate_hash_set");
    end
    $finish;
  end

endmodule
